// File: hw/rtl/bf3r_pkg.sv
package bf3r_pkg;

  // Field widths of the pixel stream and the result stream.
  localparam int PIX_W     = 8;
  localparam int COORD_W   = 10;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;

  // Default geometry limits and register reset value.
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam logic [CFG_W-1:0] DIM_RESET = 11'd256;
  localparam int DIM_MIN = 3;

  // A 3x3 sum of 8-bit pixels needs 12 bits.
  localparam int SUM_W = 12;

  // Division by nine as a multiply by ceil(2^15 / 9) and a shift; exact for
  // every sum up to 9 * 255.
  localparam int RECIP_W = 12;
  localparam logic [RECIP_W-1:0] DIV9_RECIP = 12'd3641;
  localparam int DIV9_SHIFT = 15;

  // Results an input pixel can release: top row, top row right edge,
  // bottom row, bottom row right edge.
  localparam int NUM_RES = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  // Window cells indexed [row][col]; row 0 is the oldest line, col 2 the
  // newest column.
  typedef logic [2:0][2:0][PIX_W-1:0] window_t;

  // Per-pixel job control handed to the result sequencer.
  typedef struct packed {
    logic [NUM_RES-1:0] mask;
    logic               row_one;
    logic               col_one;
  } job_ctl_t;

  // One result beat before the divide.
  typedef struct packed {
    logic [SUM_W-1:0]   sum;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               last;
  } sum_beat_t;

endpackage

// File: hw/rtl/bf3r_if.sv
interface bf3r_pix_if;
  logic                      valid;
  logic                      ready;
  logic [bf3r_pkg::PIX_W-1:0] pixel_in;

  modport source(output valid, output pixel_in, input ready);
  modport sink(input valid, input pixel_in, output ready);
endinterface

interface bf3r_res_if;
  logic                        valid;
  logic                        ready;
  logic [bf3r_pkg::PIX_W-1:0]   mean_value;
  logic [bf3r_pkg::COORD_W-1:0] out_row;
  logic [bf3r_pkg::COORD_W-1:0] out_col;
  logic                        last_of_run;

  modport source(output valid, output mean_value, output out_row, output out_col,
                 output last_of_run, input ready);
  modport sink(input valid, input mean_value, input out_row, input out_col,
               input last_of_run, output ready);
endinterface

// File: hw/rtl/bf3r_line_mem.sv
module bf3r_line_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 8
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_q_r;

  // Single write port, one registered read port. A read of the entry being
  // written in the same cycle returns the new data.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_q_r <= wr_data;
      end else begin
        rd_q_r <= mem[rd_addr];
      end
    end
  end

  assign rd_data = rd_q_r;

endmodule

// File: hw/rtl/bf3r_result_seq.sv
module bf3r_result_seq #(
  parameter int RW = 10,
  parameter int CW = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  bf3r_pkg::job_ctl_t  job_ctl,
  input  logic [RW-1:0]       job_row,
  input  logic [CW-1:0]       job_col,
  input  bf3r_pkg::window_t   win,
  output logic                free,
  output logic                beat_valid,
  output bf3r_pkg::sum_beat_t beat,
  input  logic                beat_ready
);

  import bf3r_pkg::*;

  logic [NUM_RES-1:0] mask_r;
  logic               row_one_r;
  logic               col_one_r;
  logic [RW-1:0]      row_r;
  logic [CW-1:0]      col_r;

  logic               beat_v_r;
  sum_beat_t          beat_r;

  logic [NUM_RES-1:0] sel;
  logic [NUM_RES-1:0] mask_after;
  logic               emit;
  logic               bottom;
  logic               edge_col;
  logic [1:0]         row_a, row_b, row_c;
  logic [1:0]         col_a, col_b, col_c;
  logic [SUM_W-1:0]   col_sum [3];
  logic [SUM_W-1:0]   sum_sel;
  logic [RW-1:0]      row_sel;
  logic [CW-1:0]      col_sel;

  // Pick the earliest pending result.
  always_comb begin
    sel = '0;
    priority if (mask_r[0]) begin
      sel[0] = 1'b1;
    end else if (mask_r[1]) begin
      sel[1] = 1'b1;
    end else if (mask_r[2]) begin
      sel[2] = 1'b1;
    end else if (mask_r[3]) begin
      sel[3] = 1'b1;
    end
  end

  assign mask_after = mask_r & ~sel;
  assign emit       = (|mask_r) && (!beat_v_r || beat_ready);
  assign free       = (mask_r == '0) || (emit && (mask_after == '0));

  // Mirrored row and column slots of the selected result.
  assign bottom   = sel[2] | sel[3];
  assign edge_col = sel[1] | sel[3];

  always_comb begin
    if (bottom) begin
      row_a = 2'd1;
      row_b = 2'd2;
      row_c = 2'd1;
    end else begin
      row_a = row_one_r ? 2'd2 : 2'd0;
      row_b = 2'd1;
      row_c = 2'd2;
    end
    if (edge_col) begin
      col_a = 2'd1;
      col_b = 2'd2;
      col_c = 2'd1;
    end else begin
      col_a = col_one_r ? 2'd2 : 2'd0;
      col_b = 2'd1;
      col_c = 2'd2;
    end
  end

  // Column sums over the chosen rows, then the chosen columns.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      col_sum[c] = SUM_W'(win[row_a][c]) + SUM_W'(win[row_b][c]) + SUM_W'(win[row_c][c]);
    end
    sum_sel = col_sum[col_a] + col_sum[col_b] + col_sum[col_c];
    row_sel = bottom ? row_r : row_r - RW'(1);
    col_sel = edge_col ? col_r : col_r - CW'(1);
  end

  // Job register: loaded when the previous job has released its last result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else if (load) begin
      mask_r <= job_ctl.mask;
    end else if (emit) begin
      mask_r <= mask_after;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      row_one_r <= job_ctl.row_one;
      col_one_r <= job_ctl.col_one;
      row_r     <= job_row;
      col_r     <= job_col;
    end
  end

  // Sum beat register toward the divider.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_v_r <= 1'b0;
    end else if (emit) begin
      beat_v_r <= 1'b1;
    end else if (beat_ready) begin
      beat_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      beat_r.sum  <= sum_sel;
      beat_r.row  <= COORD_W'(row_sel);
      beat_r.col  <= COORD_W'(col_sel);
      beat_r.last <= (mask_after == '0);
    end
  end

  assign beat_valid = beat_v_r;
  assign beat       = beat_r;

endmodule

// File: hw/rtl/bf3r_div9.sv
module bf3r_div9 (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                beat_valid,
  input  bf3r_pkg::sum_beat_t beat,
  output logic                beat_ready,
  bf3r_res_if.source          res
);

  import bf3r_pkg::*;

  logic                       out_v_r;
  logic [PIX_W-1:0]           mean_r;
  logic [COORD_W-1:0]         row_r;
  logic [COORD_W-1:0]         col_r;
  logic                       last_r;
  logic [SUM_W+RECIP_W-1:0]   prod;

  // Divide by nine via the reciprocal.
  assign prod       = (SUM_W + RECIP_W)'(beat.sum) * (SUM_W + RECIP_W)'(DIV9_RECIP);
  assign beat_ready = !out_v_r || res.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (beat_valid && beat_ready) begin
      out_v_r <= 1'b1;
    end else if (res.ready) begin
      out_v_r <= 1'b0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (beat_valid && beat_ready) begin
      mean_r <= prod[DIV9_SHIFT +: PIX_W];
      row_r  <= beat.row;
      col_r  <= beat.col;
      last_r <= beat.last;
    end
  end

  assign res.valid       = out_v_r;
  assign res.mean_value  = mean_r;
  assign res.out_row     = row_r;
  assign res.out_col     = col_r;
  assign res.last_of_run = last_r;

endmodule

// File: hw/rtl/box_filter_3x3_reflect.sv
// Channel    Dir  Beat fields                                   Handshake
// in_px      in   pixel_in                                      valid/ready
// out_res    out  mean_value, out_row, out_col, last_of_run     valid/ready
// cfg        in   cfg_idx, cfg_data                             cfg_we
//
// One pixel beat per cycle is accepted while each pixel releases at most one
// result and out_res is ready; a pixel with n results holds the sequencer
// until all are out, one result beat per cycle while out_res is ready. Path
// to a first result: line memory read, result sequencer, sum register, divider.
// Reset is synchronous and active low; the line memories are not cleared.
// A stall on out_res backs up through the sum and output registers to in_px.
module box_filter_3x3_reflect #(
  parameter int MAX_WIDTH  = bf3r_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bf3r_pkg::MAX_HEIGHT_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  bf3r_pix_if.sink                         in_px,
  bf3r_res_if.source                       out_res,
  input  logic                             cfg_we,
  input  logic [bf3r_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [bf3r_pkg::CFG_W-1:0]       cfg_data
);

  import bf3r_pkg::*;

  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int RW     = $clog2(MAX_HEIGHT);
  localparam int DIMW_W = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
  localparam int DIMH_W = (RW + 1 > CFG_W) ? RW + 1 : CFG_W;

  logic [CFG_W-1:0]  width_r;
  logic [CFG_W-1:0]  height_r;
  logic [DIMW_W-1:0] w_ext, w_cl;
  logic [DIMH_W-1:0] h_ext, h_cl;
  logic [CW-1:0]     w_last;
  logic [RW-1:0]     h_last;

  logic [CW-1:0]     col_r;
  logic [RW-1:0]     row_r;

  logic              s1_v_r;
  logic [CW-1:0]     s1_col_r;
  logic [RW-1:0]     s1_row_r;
  logic [PIX_W-1:0]  s1_px_r;

  logic              accept;
  logic              s1_adv;
  logic              seq_free;
  logic [PIX_W-1:0]  older_q;
  logic [PIX_W-1:0]  newer_q;

  window_t           window_r;
  job_ctl_t          job_ctl;

  logic              beat_valid;
  logic              beat_ready;
  sum_beat_t         beat;

  // Clamp the geometry registers to the supported range.
  always_comb begin
    w_ext = DIMW_W'(width_r);
    h_ext = DIMH_W'(height_r);
    if (w_ext < DIMW_W'(DIM_MIN)) begin
      w_cl = DIMW_W'(DIM_MIN);
    end else if (w_ext > DIMW_W'(MAX_WIDTH)) begin
      w_cl = DIMW_W'(MAX_WIDTH);
    end else begin
      w_cl = w_ext;
    end
    if (h_ext < DIMH_W'(DIM_MIN)) begin
      h_cl = DIMH_W'(DIM_MIN);
    end else if (h_ext > DIMH_W'(MAX_HEIGHT)) begin
      h_cl = DIMH_W'(MAX_HEIGHT);
    end else begin
      h_cl = h_ext;
    end
    w_last = CW'(w_cl - DIMW_W'(1));
    h_last = RW'(h_cl - DIMH_W'(1));
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_RESET;
      height_r <= DIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_e'(cfg_idx))
        REG_IMAGE_WIDTH:  width_r  <= cfg_data;
        REG_IMAGE_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake of the pixel stage.
  assign s1_adv       = s1_v_r && seq_free;
  assign in_px.ready  = !s1_v_r || seq_free;
  assign accept       = in_px.valid && in_px.ready;

  // Raster position of the next pixel; a configuration write restarts the frame.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (cfg_we) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      if (col_r == w_last) begin
        col_r <= '0;
        row_r <= (row_r == h_last) ? '0 : row_r + RW'(1);
      end else begin
        col_r <= col_r + CW'(1);
      end
    end
  end

  // Pixel stage: holds the beat while the line memories are read.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (accept) begin
      s1_v_r <= 1'b1;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col_r <= col_r;
      s1_row_r <= row_r;
      s1_px_r  <= in_px.pixel_in;
    end
  end

  // Two line memories: the line two above and the line just above.
  bf3r_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW),
    .DW    (PIX_W)
  ) u_older_mem (
    .clk     (clk),
    .wr_en   (s1_adv),
    .wr_addr (s1_col_r),
    .wr_data (newer_q),
    .rd_en   (accept),
    .rd_addr (col_r),
    .rd_data (older_q)
  );

  bf3r_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW),
    .DW    (PIX_W)
  ) u_newer_mem (
    .clk     (clk),
    .wr_en   (s1_adv),
    .wr_addr (s1_col_r),
    .wr_data (s1_px_r),
    .rd_en   (accept),
    .rd_addr (col_r),
    .rd_data (newer_q)
  );

  // Window shifts left one column as the pixel moves on.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
    end else if (s1_adv) begin
      for (int r = 0; r < 3; r++) begin
        window_r[r][0] <= window_r[r][1];
        window_r[r][1] <= window_r[r][2];
      end
      window_r[0][2] <= older_q;
      window_r[1][2] <= newer_q;
      window_r[2][2] <= s1_px_r;
    end
  end

  // Which results this pixel releases.
  always_comb begin
    job_ctl.mask[0] = (s1_col_r != '0) && (s1_row_r != '0);
    job_ctl.mask[1] = job_ctl.mask[0] && (s1_col_r == w_last);
    job_ctl.mask[2] = (s1_col_r != '0) && (s1_row_r == h_last);
    job_ctl.mask[3] = job_ctl.mask[2] && (s1_col_r == w_last);
    job_ctl.row_one = (s1_row_r == RW'(1));
    job_ctl.col_one = (s1_col_r == CW'(1));
  end

  bf3r_result_seq #(
    .RW (RW),
    .CW (CW)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (s1_adv),
    .job_ctl    (job_ctl),
    .job_row    (s1_row_r),
    .job_col    (s1_col_r),
    .win        (window_r),
    .free       (seq_free),
    .beat_valid (beat_valid),
    .beat       (beat),
    .beat_ready (beat_ready)
  );

  bf3r_div9 u_div9 (
    .clk        (clk),
    .rst_n      (rst_n),
    .beat_valid (beat_valid),
    .beat       (beat),
    .beat_ready (beat_ready),
    .res        (out_res)
  );

endmodule

// File: verif/box_filter_3x3_reflect_checker.sv
`timescale 1ns / 1ps

module box_filter_3x3_reflect_checker
  import bf3r_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  bf3r_pix_if                  in_px,
  bf3r_res_if                  out_res,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   mismatch_count,
  output int                   means_pending
);

  localparam int LINE_DEPTH  = MAX_WIDTH_DEF;
  localparam int CELLS       = 9;
  localparam int REPORT_MAX  = 10;

  typedef struct packed {
    logic [PIX_W-1:0]   mean;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               last;
  } mean_beat_t;

  // Shadow copy of the filter state.
  logic [CFG_W-1:0]   width_reg;
  logic [CFG_W-1:0]   height_reg;
  logic [PIX_W-1:0]   older_line [LINE_DEPTH];
  logic [PIX_W-1:0]   newer_line [LINE_DEPTH];
  logic [PIX_W-1:0]   win [3][3];
  logic [COORD_W-1:0] row_pos;
  logic [COORD_W-1:0] col_pos;

  // Means predicted but not yet seen on the result channel, oldest first.
  mean_beat_t means_due [$];

  // Out-of-range geometry is clamped to what the block supports.
  function automatic int effective_dim(logic [CFG_W-1:0] code, int limit);
    if (code < DIM_MIN) return DIM_MIN;
    if (code > limit) return limit;
    return int'(code);
  endfunction

  // Sum of the nine window cells picked by three row slots and three column
  // slots; mirrored borders pick the same slot twice.
  function automatic int window_total(int r0, int r1, int r2, int c0, int c1, int c2);
    int rs[3];
    int cs[3];
    int total;
    rs = '{r0, r1, r2};
    cs = '{c0, c1, c2};
    total = 0;
    for (int a = 0; a < 3; a++) begin
      for (int b = 0; b < 3; b++) begin
        total += win[rs[a]][cs[b]];
      end
    end
    return total;
  endfunction

  task automatic queue_mean(input int total, input int r, input int c);
    mean_beat_t beat;
    beat.mean = PIX_W'(total / CELLS);
    beat.row  = COORD_W'(r);
    beat.col  = COORD_W'(c);
    beat.last = 1'b0;
    means_due.push_back(beat);
  endtask

  always @(posedge clk) begin : predict_and_compare
    int w;
    int h;
    int i;
    int j;
    int col_first;
    int row_first;
    int queued_before;
    mean_beat_t got;
    mean_beat_t want;

    if (!rst_n) begin
      width_reg  = DIM_RESET;
      height_reg = DIM_RESET;
      for (int k = 0; k < LINE_DEPTH; k++) begin
        older_line[k] = '0;
        newer_line[k] = '0;
      end
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win[r][c] = '0;
        end
      end
      row_pos = '0;
      col_pos = '0;
      means_due.delete();
      mismatch_count = 0;
    end else begin
      // A register write also restarts the frame.
      if (cfg_we) begin
        case (cfg_reg_e'(cfg_idx))
          REG_IMAGE_WIDTH:  width_reg  = cfg_data;
          REG_IMAGE_HEIGHT: height_reg = cfg_data;
          default: ;
        endcase
        row_pos = '0;
        col_pos = '0;
      end

      // Pixel beat: shift the window, rotate the line stores, release means.
      if (in_px.valid && in_px.ready) begin
        w = effective_dim(width_reg, MAX_WIDTH_DEF);
        h = effective_dim(height_reg, MAX_HEIGHT_DEF);
        i = int'(row_pos);
        j = int'(col_pos);
        if (j >= w) j = 0;
        if (i >= h) i = 0;

        for (int r = 0; r < 3; r++) begin
          win[r][0] = win[r][1];
          win[r][1] = win[r][2];
        end
        win[0][2] = older_line[j];
        win[1][2] = newer_line[j];
        win[2][2] = in_px.pixel_in;
        older_line[j] = newer_line[j];
        newer_line[j] = in_px.pixel_in;

        queued_before = means_due.size();
        if (j >= 1) begin
          // Left border mirrors column 1 onto column -1.
          col_first = (j == 1) ? 2 : 0;
          if (i >= 1) begin
            // Top border mirrors row 1 onto row -1.
            row_first = (i == 1) ? 2 : 0;
            queue_mean(window_total(row_first, 1, 2, col_first, 1, 2), i - 1, j - 1);
            if (j == w - 1) begin
              queue_mean(window_total(row_first, 1, 2, 1, 2, 1), i - 1, j);
            end
          end
          // Bottom row: row H mirrors row H-2.
          if (i == h - 1) begin
            queue_mean(window_total(1, 2, 1, col_first, 1, 2), i, j - 1);
            if (j == w - 1) begin
              queue_mean(window_total(1, 2, 1, 1, 2, 1), i, j);
            end
          end
        end
        if (means_due.size() > queued_before) begin
          means_due[means_due.size() - 1].last = 1'b1;
        end

        j++;
        if (j >= w) begin
          j = 0;
          i++;
          if (i >= h) i = 0;
        end
        col_pos = COORD_W'(j);
        row_pos = COORD_W'(i);
      end

      // Result beat: compare with the oldest predicted mean.
      if (out_res.valid && out_res.ready) begin
        got.mean = out_res.mean_value;
        got.row  = out_res.out_row;
        got.col  = out_res.out_col;
        got.last = out_res.last_of_run;
        if (means_due.size() == 0) begin
          if (mismatch_count < REPORT_MAX) begin
            $display("%0t: unexpected result beat: mean %0d row %0d col %0d last %0b",
                     $realtime, got.mean, got.row, got.col, got.last);
          end
          mismatch_count++;
        end else begin
          want = means_due.pop_front();
          if (got !== want) begin
            if (mismatch_count < REPORT_MAX) begin
              $display("%0t: result mismatch: expected mean %0d row %0d col %0d last %0b,",
                       $realtime, want.mean, want.row, want.col, want.last);
              $display("    got mean %0d row %0d col %0d last %0b",
                       got.mean, got.row, got.col, got.last);
            end
            mismatch_count++;
          end
        end
      end
    end
    means_pending = means_due.size();
  end

endmodule

// File: verif/box_filter_3x3_reflect_test.sv
`timescale 1ns / 1ps

module box_filter_3x3_reflect_test;
  import bf3r_pkg::*;

  localparam int IDLE_LIMIT    = 4000;
  localparam int SETTLE_CYCLES = 12;
  localparam int RANDOM_ITEMS  = 90;
  localparam int RESET_CYCLES  = 6;

  typedef enum int {
    RX_OPEN,
    RX_COIN,
    RX_PERIODIC,
    RX_CHOKED
  } rx_mode_e;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;
  int                   mismatch_count;
  int                   means_pending;

  bf3r_pix_if in_if ();
  bf3r_res_if res_if ();

  int       burst_left;
  bit       gaps_on;
  rx_mode_e rx_mode;
  int       rx_left;
  int       rx_tick;
  int       idle_cycles;
  int       cur_w;
  int       cur_h;
  int       random_sent;

  box_filter_3x3_reflect u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_px    (in_if),
    .out_res  (res_if),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  box_filter_3x3_reflect_checker u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_px          (in_if),
    .out_res        (res_if),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .means_pending  (means_pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side back-pressure: the pattern switches among open, coin-flip,
  // periodic and mostly-stalled stretches.
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(16, 160);
    end
    rx_left--;
    rx_tick++;
    case (rx_mode)
      RX_OPEN:     res_if.ready <= 1'b1;
      RX_COIN:     res_if.ready <= 1'($urandom_range(0, 1));
      RX_PERIODIC: res_if.ready <= ((rx_tick % 5) > 1);
      default:     res_if.ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL box_filter_3x3_reflect");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Pixel values lean on the extremes so that means of 0 and 255 show up.
  function automatic logic [PIX_W-1:0] pick_pixel();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Register code for a wanted geometry; the minimum is sometimes reached
  // through a value below it that the block must clamp.
  function automatic logic [CFG_W-1:0] dim_code(int dim);
    if (dim == DIM_MIN && $urandom_range(0, 2) == 0) begin
      return CFG_W'($urandom_range(0, DIM_MIN - 1));
    end
    return CFG_W'(dim);
  endfunction

  // Send one pixel beat; random-length bursts, with random gaps between if gaps_on.
  task automatic send_pixel(input logic [PIX_W-1:0] px);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = gaps_on ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
        @(negedge clk);
        in_if.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    in_if.valid    <= 1'b1;
    in_if.pixel_in <= px;
    burst_left--;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic stop_sending();
    @(negedge clk);
    in_if.valid <= 1'b0;
    burst_left = 0;
  endtask

  // Wait until every predicted mean has come, then let the pipeline empty.
  task automatic settle();
    stop_sending();
    while (means_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_W-1:0] code);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= code;
  endtask

  task automatic close_writes();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // A run of random pixels, optionally holding off once mid-run until the
  // result channel has drained.
  task automatic run_pixels(input int count, input bit with_pause);
    int pause_at;
    pause_at = (with_pause && count > 2) ? $urandom_range(1, count - 2) : -1;
    for (int k = 0; k < count; k++) begin
      if (k == pause_at) begin
        stop_sending();
        while (means_pending != 0) @(negedge clk);
      end
      send_pixel(pick_pixel());
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = REG_IMAGE_WIDTH;
    cfg_data       = '0;
    in_if.valid    = 1'b0;
    in_if.pixel_in = '0;
    res_if.ready   = 1'b0;
    gaps_on        = 1'b1;
    burst_left     = 0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // Reset geometry is 256 x 256: one row and a few pixels release the
    // start of the top row.
    run_pixels(256 + 8, 1'b1);

    // Smallest frame, all white: every mean is 255.
    settle();
    write_reg(REG_IMAGE_WIDTH, 11'd3);
    write_reg(REG_IMAGE_HEIGHT, 11'd3);
    close_writes();
    repeat (9) send_pixel('1);

    // Smallest frame reached by clamping from below, alternating black and
    // white so that every mirrored border shows in the sums.
    settle();
    write_reg(REG_IMAGE_WIDTH, 11'd0);
    write_reg(REG_IMAGE_HEIGHT, 11'd2);
    close_writes();
    for (int k = 0; k < 9; k++) begin
      send_pixel((k % 2 == 1) ? '1 : '0);
    end

    // Widest row, clamped from the top code; the start of the first row must
    // release nothing.
    settle();
    write_reg(REG_IMAGE_WIDTH, '1);
    write_reg(REG_IMAGE_HEIGHT, 11'd1);
    close_writes();
    run_pixels(24, 1'b1);

    // Tallest frame, clamped from the top code, three pixels wide; the first
    // ten rows must not be taken for the bottom row.
    settle();
    write_reg(REG_IMAGE_WIDTH, 11'd2);
    write_reg(REG_IMAGE_HEIGHT, '1);
    close_writes();
    run_pixels(3 * 10, 1'b1);

    // Just above the width limit and exactly the height limit, no sender
    // gaps; the frame is cut short and the next write restarts it.
    settle();
    gaps_on = 1'b0;
    write_reg(REG_IMAGE_WIDTH, CFG_W'(MAX_WIDTH_DEF + 1));
    write_reg(REG_IMAGE_HEIGHT, CFG_W'(MAX_HEIGHT_DEF));
    close_writes();
    run_pixels(24, 1'b0);

    // Random small geometries: mostly whole frames, some cut short.
    random_sent = 0;
    cur_w = 0;
    while (random_sent < RANDOM_ITEMS) begin : random_phase
      int new_w;
      int new_h;
      int count;
      new_w = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(3, 10);
      new_h = $urandom_range(3, 6);
      settle();
      case ((cur_w == 0) ? 3 : $urandom_range(0, 3))
        0: begin
          write_reg(REG_IMAGE_WIDTH, dim_code(new_w));
          cur_w = new_w;
        end
        1: begin
          write_reg(REG_IMAGE_HEIGHT, dim_code(new_h));
          cur_h = new_h;
        end
        2: begin
          // Overwrite the width before use; only the second value counts.
          write_reg(REG_IMAGE_WIDTH, CFG_W'($urandom_range(0, 2047)));
          write_reg(REG_IMAGE_WIDTH, dim_code(new_w));
          write_reg(REG_IMAGE_HEIGHT, dim_code(new_h));
          cur_w = new_w;
          cur_h = new_h;
        end
        default: begin
          write_reg(REG_IMAGE_HEIGHT, dim_code(new_h));
          write_reg(REG_IMAGE_WIDTH, dim_code(new_w));
          cur_w = new_w;
          cur_h = new_h;
        end
      endcase
      close_writes();
      gaps_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 3) == 0) begin
        count = $urandom_range(1, 2 * cur_w * cur_h);
      end else begin
        count = cur_w * cur_h * $urandom_range(1, 2);
      end
      run_pixels(count, ($urandom_range(0, 2) == 0));
      random_sent += count;
    end

    settle();
    if (mismatch_count == 0 && means_pending == 0) begin
      $display("PASS box_filter_3x3_reflect");
    end else begin
      $display("FAIL box_filter_3x3_reflect");
    end
    $finish;
  end

endmodule
